// File: sv/glyph_slot_cache_policy_defines.svh
// ----------------------------------------------------------------------------
// Glyph slot cache policy assertion macros
// Shared concurrent assertion forms, clocked on clk_i and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef GLYPH_SLOT_CACHE_POLICY_DEFINES_SVH
`define GLYPH_SLOT_CACHE_POLICY_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define GSCP_ASSERT(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("gscp assertion failed");

// A trigger that must be followed by a condition in the next cycle.
`define GSCP_ASSERT_NEXT(name, trig, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error("gscp assertion failed");

`endif

// File: sv/gscp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph slot cache policy package
// Sizes, special codepoints and shared types of the glyph slot cache policy.
// ----------------------------------------------------------------------------
package gscp_pkg;

  localparam int ASSOC_ENTRIES = 16;
  localparam int DIRECT_FIRST  = 32;
  localparam int DIRECT_LAST   = 126;

  localparam int CP_W        = 21;
  localparam int SLOT_W      = 7;
  localparam int STAMP_W     = 32;
  localparam int ASSOC_AW    = (ASSOC_ENTRIES > 1) ? $clog2(ASSOC_ENTRIES) : 1;
  localparam int DIRECT_CNT  = DIRECT_LAST - DIRECT_FIRST + 1;
  localparam int DIRECT_AW   = (DIRECT_CNT > 1) ? $clog2(DIRECT_CNT) : 1;

  // Codepoints below CTRL_LIMIT and DEL_CODE are shown as SUBST_CODE ('?').
  localparam logic [CP_W-1:0] CTRL_LIMIT = CP_W'(32'h20);
  localparam logic [CP_W-1:0] DEL_CODE   = CP_W'(32'h7F);
  localparam logic [CP_W-1:0] SUBST_CODE = CP_W'(32'h3F);

  localparam logic             FUNC_LOOKUP = 1'b0;
  localparam logic             FUNC_CLEAR  = 1'b1;

  typedef struct packed {
    logic [CP_W-1:0]    tag;
    logic [STAMP_W-1:0] stamp;
    logic               ready;
  } entry_t;

  typedef struct packed {
    logic [CP_W-1:0]   used_codepoint;
    logic              in_direct_range;
    logic [SLOT_W-1:0] slot_number;
    logic              tag_hit;
    logic              render_attempted;
    logic              glyph_ready;
  } res_t;

endpackage

// File: sv/gscp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph slot cache policy channels
// Valid/ready interfaces for the request words and the result words.
// ----------------------------------------------------------------------------
interface gscp_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [gscp_pkg::CP_W-1:0]   codepoint;
  logic                        render_ok;

  modport source (output valid, output func, output codepoint, output render_ok,
                  input ready);
  modport sink (input valid, input func, input codepoint, input render_ok,
                output ready);
endinterface

interface gscp_out_if;
  logic                        valid;
  logic                        ready;
  logic [gscp_pkg::CP_W-1:0]   used_codepoint;
  logic                        in_direct_range;
  logic [gscp_pkg::SLOT_W-1:0] slot_number;
  logic                        tag_hit;
  logic                        render_attempted;
  logic                        glyph_ready;

  modport source (output valid, output used_codepoint, output in_direct_range,
                  output slot_number, output tag_hit, output render_attempted,
                  output glyph_ready, input ready);
  modport sink (input valid, input used_codepoint, input in_direct_range,
                input slot_number, input tag_hit, input render_attempted,
                input glyph_ready, output ready);
endinterface

// File: sv/glyph_slot_cache_policy.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph slot cache policy
// Chooses the cache slot for a glyph: direct slots for a fixed codepoint range,
// a fully associative LRU set for everything else, and a cache clear command.
// ----------------------------------------------------------------------------
// Each request word gives one result word. Direct-range lookups and clears
// go from acceptance to the S_DONE state and from there into the output
// register. An associative lookup reads the entry memory one entry per cycle
// through its single read port: after acceptance it walks the entries in
// S_WALK (the walk stops at the first matching tag, else it examines every
// entry), writes back in S_WRITE and hands the result over in S_DONE. The
// next request word is taken once the result has moved to the output
// register, which may still be waiting for the consumer. There is no
// clearing pass after reset: the direct ready bits and the per-entry valid
// bits are flops cleared at once by reset or by a clear word.
module glyph_slot_cache_policy (
  input  logic        clk_i,
  input  logic        rst_ni,
  gscp_in_if.sink     in_i,
  gscp_out_if.source  out_o
);

`include "glyph_slot_cache_policy_defines.svh"

  localparam int AW = gscp_pkg::ASSOC_AW;
  localparam int NE = gscp_pkg::ASSOC_ENTRIES;
  localparam int ND = gscp_pkg::DIRECT_CNT;
  localparam int DW = gscp_pkg::DIRECT_AW;
  localparam int CW = gscp_pkg::CP_W;
  localparam int SW = gscp_pkg::STAMP_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(NE - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_DONE  = 3'd3;

  // Control and payload registers.
  logic [2:0]           state_q, state_d;
  logic [CW-1:0]        cp_q, cp_d;
  logic                 ok_q, ok_d;
  logic [SW-1:0]        tick_q, tick_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic [NE-1:0]        vld_q, vld_d;
  logic [ND-1:0]        dready_q, dready_d;
  logic [AW-1:0]        empty_q, empty_d;
  logic                 has_empty_q, has_empty_d;
  logic [AW-1:0]        oldest_q, oldest_d;
  logic [SW-1:0]        old_stamp_q, old_stamp_d;
  logic [AW-1:0]        sel_q, sel_d;
  logic                 hit_q, hit_d;
  logic                 sel_ready_q, sel_ready_d;
  gscp_pkg::res_t       res_q, res_d;
  gscp_pkg::res_t       out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  // Entry memory: tag, use stamp and ready bit per associative entry. Reads
  // and the write-back never fall in the same cycle, so no forwarding is
  // needed; an entry whose valid bit is low reads as all zero.
  gscp_pkg::entry_t     mem [NE];
  gscp_pkg::entry_t     rd_q;
  gscp_pkg::entry_t     mem_wd;
  gscp_pkg::entry_t     cur;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [AW-1:0]        mem_ra;

  // Request decode.
  logic                 in_acc;
  logic [CW-1:0]        cp_sub;
  logic                 is_direct;
  logic [CW-1:0]        dofs;
  logic [DW-1:0]        didx;
  logic                 cur_hit;
  logic                 wr_attempt;
  logic                 wr_ready;

  // A new word is taken only while no other word is in flight.
  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  // Control codes and DEL are drawn as a question mark.
  assign cp_sub = ((in_i.codepoint < gscp_pkg::CTRL_LIMIT) ||
                   (in_i.codepoint == gscp_pkg::DEL_CODE)) ?
                  gscp_pkg::SUBST_CODE : in_i.codepoint;
  assign is_direct = (cp_sub >= CW'(gscp_pkg::DIRECT_FIRST)) &&
                     (cp_sub <= CW'(gscp_pkg::DIRECT_LAST));
  assign dofs = cp_sub - CW'(gscp_pkg::DIRECT_FIRST);
  assign didx = dofs[DW-1:0];

  assign cur     = vld_q[idx_q] ? rd_q : '0;
  assign cur_hit = (cur.tag == cp_q);

  // A hit on a ready entry is the only write-back that does not render.
  assign wr_attempt = !hit_q || !sel_ready_q;
  assign wr_ready   = wr_attempt ? ok_q : 1'b1;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[mem_ra];
  end

  always_comb begin
    state_d     = state_q;
    cp_d        = cp_q;
    ok_d        = ok_q;
    tick_d      = tick_q;
    idx_d       = idx_q;
    vld_d       = vld_q;
    dready_d    = dready_q;
    empty_d     = empty_q;
    has_empty_d = has_empty_q;
    oldest_d    = oldest_q;
    old_stamp_d = old_stamp_q;
    sel_d       = sel_q;
    hit_d       = hit_q;
    sel_ready_d = sel_ready_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_wa      = sel_q;
    mem_wd      = '0;
    mem_ra      = '0;

    // The consumer drains the output register; a new result may refill it.
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cp_d  = cp_sub;
          ok_d  = in_i.render_ok;
          res_d = '0;
          if (in_i.func == gscp_pkg::FUNC_CLEAR) begin
            vld_d    = '0;
            dready_d = '0;
            tick_d   = '0;
            state_d  = S_DONE;
          end else if (is_direct) begin
            res_d.used_codepoint   = cp_sub;
            res_d.in_direct_range  = 1'b1;
            res_d.slot_number      = dofs[gscp_pkg::SLOT_W-1:0];
            res_d.render_attempted = !dready_q[didx];
            res_d.glyph_ready      = dready_q[didx] || in_i.render_ok;
            if (!dready_q[didx]) begin
              dready_d[didx] = in_i.render_ok;
            end
            state_d = S_DONE;
          end else begin
            // Start the walk: entry 0 is read now and examined next cycle.
            tick_d      = tick_q + 1'b1;
            idx_d       = '0;
            has_empty_d = 1'b0;
            hit_d       = 1'b0;
            mem_ra      = '0;
            state_d     = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (cur_hit) begin
          sel_d       = idx_q;
          hit_d       = 1'b1;
          sel_ready_d = cur.ready;
          state_d     = S_WRITE;
        end else begin
          // The highest not-ready entry wins as victim; otherwise the first
          // entry with the strictly smallest stamp.
          if (!cur.ready) begin
            empty_d     = idx_q;
            has_empty_d = 1'b1;
          end
          if ((idx_q == '0) || (cur.stamp < old_stamp_q)) begin
            oldest_d    = idx_q;
            old_stamp_d = cur.stamp;
          end
          if (idx_q == LAST_IDX) begin
            hit_d   = 1'b0;
            sel_d   = has_empty_d ? empty_d : oldest_d;
            state_d = S_WRITE;
          end else begin
            idx_d  = idx_q + 1'b1;
            mem_ra = idx_q + 1'b1;
          end
        end
      end

      S_WRITE: begin
        mem_we       = 1'b1;
        mem_wa       = sel_q;
        mem_wd.tag   = cp_q;
        mem_wd.stamp = tick_q;
        mem_wd.ready = wr_ready;
        vld_d[sel_q] = 1'b1;
        res_d.used_codepoint   = cp_q;
        res_d.in_direct_range  = 1'b0;
        res_d.slot_number      = gscp_pkg::SLOT_W'(sel_q);
        res_d.tag_hit          = hit_q;
        res_d.render_attempted = wr_attempt;
        res_d.glyph_ready      = wr_ready;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tick_q      <= '0;
      vld_q       <= '0;
      dready_q    <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      vld_q       <= vld_d;
      dready_q    <= dready_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q        <= cp_d;
    ok_q        <= ok_d;
    empty_q     <= empty_d;
    has_empty_q <= has_empty_d;
    oldest_q    <= oldest_d;
    old_stamp_q <= old_stamp_d;
    sel_q       <= sel_d;
    hit_q       <= hit_d;
    sel_ready_q <= sel_ready_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.used_codepoint   = out_q.used_codepoint;
  assign out_o.in_direct_range  = out_q.in_direct_range;
  assign out_o.slot_number      = out_q.slot_number;
  assign out_o.tag_hit          = out_q.tag_hit;
  assign out_o.render_attempted = out_q.render_attempted;
  assign out_o.glyph_ready      = out_q.glyph_ready;

  // The walk moves one entry at a time until a tag matches or it ends.
  `GSCP_ASSERT_NEXT(a_walk_step,
    (state_q == S_WALK) && !cur_hit && (idx_q != LAST_IDX),
    (state_q == S_WALK) && (idx_q == $past(idx_q) + 1'b1))
  // A clear word restarts the use counter and clears the entry valid bits.
  `GSCP_ASSERT_NEXT(a_clear_tick, in_acc && (in_i.func == gscp_pkg::FUNC_CLEAR),
    (tick_q == '0) && (vld_q == '0))
  // A slot that needed no render was already holding a glyph.
  `GSCP_ASSERT(a_ready_no_render,
    !(out_o.valid && !out_o.render_attempted &&
      (out_o.in_direct_range || out_o.tag_hit)) || out_o.glyph_ready)
  // An associative miss always renders into its victim.
  `GSCP_ASSERT(a_miss_renders,
    !(out_o.valid && !out_o.in_direct_range && !out_o.tag_hit &&
      (out_o.used_codepoint != '0)) || out_o.render_attempted)

endmodule
